### design/i2c_master_bit_engine_core_assert.svh
// assertion macros used by the i2c master bit engine rtl
`ifndef I2C_MASTER_BIT_ENGINE_CORE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_CORE_ASSERT_SVH

// same-cycle implication checked at every rising clock edge outside reset
`define I2CMBE_ASSERT_COMB(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked at every rising clock edge outside reset
`define I2CMBE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/i2cmbe_pkg.sv
// shared types, constants and waveform functions of the i2c master bit engine
package i2cmbe_pkg;

    // function codes on the input word
    localparam logic [2:0] FUNC_START = 3'd0;
    localparam logic [2:0] FUNC_STOP  = 3'd4;

    // default configuration and sizing
    localparam logic [15:0] PHASE_TICKS_RST = 16'd4;
    localparam int          QUEUE_DEPTH_DEF = 2;

    // line word: [3] scl drive, [2] scl value, [1] sda drive, [0] sda value
    localparam logic [3:0] BUS_RELEASED = 4'b0101;

    // phase numbers with special meaning
    localparam logic [4:0] WR_BIT_PHASES     = 5'd24;
    localparam logic [4:0] WR_ACK_PHASE      = 5'd25;
    localparam logic [4:0] RD_LAST_BIT_PHASE = 5'd16;
    localparam logic [4:0] RD_ACK_PHASE      = 5'd17;

    // command being run, idle or function code plus one
    typedef enum logic [2:0] {
        CMD_IDLE   = 3'd0,
        CMD_START  = 3'd1,
        CMD_RSTART = 3'd2,
        CMD_WRITE  = 3'd3,
        CMD_READ   = 3'd4,
        CMD_STOP   = 3'd5
    } t_cmd;

    // completion status
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BUS_BUSY = 2'd1,
        ST_NO_ACK   = 2'd2
    } t_status;

    // front classification of one incoming word
    typedef enum logic [1:0] {
        KIND_TICK     = 2'd0,
        KIND_BUS_BUSY = 2'd1,
        KIND_CMD      = 2'd2
    } t_kind;

    // queued word after classification
    typedef struct packed {
        t_kind      kind;
        t_cmd       cmd;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_level;
    } t_item;

    // one result word
    typedef struct packed {
        logic       scl_drive;
        logic       scl_value;
        logic       sda_drive;
        logic       sda_value;
        logic       busy_res;
        logic       done_res;
        t_status    status;
        logic [7:0] rx_byte;
    } t_result;

    // both lines driven
    function automatic logic [3:0] drive_both(input logic sclv, input logic sdav);
        return {1'b1, sclv, 1'b1, sdav};
    endfunction

    // number of phases of each command
    function automatic logic [4:0] phase_count(input t_cmd cmd);
        logic [4:0] cnt;
        case (cmd)
            CMD_START:  cnt = 5'd2;
            CMD_RSTART: cnt = 5'd4;
            CMD_WRITE:  cnt = 5'd26;
            CMD_READ:   cnt = 5'd19;
            default:    cnt = 5'd4;
        endcase
        return cnt;
    endfunction

    // line word for phase p of a command
    function automatic logic [3:0] phase_lines(input t_cmd cmd, input logic [4:0] p,
                                               input logic [3:0] cur, input logic [7:0] shift,
                                               input logic ack);
        logic       sdav;
        logic [9:0] prod;
        logic [2:0] q;
        logic [4:0] sub;
        logic [3:0] lines;
        sdav = cur[0];
        // p / 3 by reciprocal, exact below 24
        prod = 10'(p) * 10'd11;
        q    = prod[7:5];
        sub  = p - 5'({2'b00, q}) * 5'd3;
        case (cmd)
            CMD_START: begin
                lines = (p == 5'd0) ? drive_both(1'b1, 1'b1) : drive_both(1'b1, 1'b0);
            end
            CMD_RSTART: begin
                if (p == 5'd0)      lines = drive_both(1'b0, sdav);
                else if (p == 5'd1) lines = drive_both(1'b0, 1'b1);
                else if (p == 5'd2) lines = drive_both(1'b1, 1'b1);
                else                lines = drive_both(1'b1, 1'b0);
            end
            CMD_WRITE: begin
                if (p < WR_BIT_PHASES) begin
                    if (sub == 5'd0) lines = drive_both(1'b0, sdav);
                    else             lines = drive_both(sub == 5'd2, shift[~q]);
                end else if (p == WR_BIT_PHASES) begin
                    lines = drive_both(1'b0, sdav);
                end else begin
                    lines = {3'b110, sdav};
                end
            end
            CMD_READ: begin
                if (p == 5'd0)                    lines = {3'b100, sdav};
                else if (p <= RD_LAST_BIT_PHASE) lines = {1'b1, p[0], 1'b0, sdav};
                else if (p == RD_ACK_PHASE)      lines = {3'b101, ~ack};
                else                             lines = {3'b111, ~ack};
            end
            default: begin
                if (p == 5'd0)      lines = drive_both(1'b0, sdav);
                else if (p == 5'd1) lines = drive_both(1'b0, 1'b0);
                else if (p == 5'd2) lines = drive_both(1'b1, 1'b0);
                else                lines = drive_both(1'b1, 1'b1);
            end
        endcase
        return lines;
    endfunction

endpackage

### design/i2cmbe_front.sv
// front end: accepts input words and classifies them for the sequencer
module i2cmbe_front import i2cmbe_pkg::*; (
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_cmd_valid,
    input  logic [2:0] i_func,
    input  logic [7:0] i_tx_byte,
    input  logic       i_send_ack,
    input  logic       i_scl_level,
    input  logic       i_sda_level,
    input  logic       i_full,
    output logic       o_push,
    output t_item      o_item
);

    logic w_func_ok;
    logic w_line_low;

    // accept whenever the queue has room
    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;

    // classify the word: plain tick, start on a busy bus, or command offer
    assign w_func_ok  = i_func inside {[FUNC_START:FUNC_STOP]};
    assign w_line_low = !i_scl_level || !i_sda_level;

    always_comb begin
        o_item.cmd       = t_cmd'(3'(i_func + 3'd1));
        o_item.tx_byte   = i_tx_byte;
        o_item.send_ack  = i_send_ack;
        o_item.sda_level = i_sda_level;
        if (!i_cmd_valid || !w_func_ok) begin
            o_item.kind = KIND_TICK;
        end else if (i_func == FUNC_START && w_line_low) begin
            o_item.kind = KIND_BUS_BUSY;
        end else begin
            o_item.kind = KIND_CMD;
        end
    end

endmodule

### design/i2cmbe_fifo.sv
// short queue of classified words between front end and sequencer
module i2cmbe_fifo import i2cmbe_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

endmodule

### design/i2cmbe_back.sv
// back end: line phase sequencer with registered result word
`include "i2c_master_bit_engine_core_assert.svh"

module i2cmbe_back import i2cmbe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_q_valid,
    input  t_item       i_q_item,
    output logic        o_q_pop,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_result     o_result
);

    t_cmd        r_cmd,   n_cmd;
    logic [4:0]  r_phase, n_phase;
    logic [15:0] r_tick,  n_tick;
    logic [7:0]  r_shift, n_shift;
    logic [3:0]  r_lines, n_lines;
    logic        r_ack,   n_ack;
    logic [7:0]  r_rx,    n_rx;
    logic [15:0] r_phase_ticks;
    logic        r_out_valid;
    t_result     r_out;

    logic        w_pop;
    logic        w_run;
    t_result     w_res;
    logic [15:0] w_ticks;
    t_cmd        w_cmd;
    logic [4:0]  w_phase;
    logic [15:0] w_tick;
    logic [7:0]  w_shift;
    logic        w_ack;
    logic [3:0]  w_lines;
    logic [16:0] w_tick_inc;
    logic        w_ack_new;
    logic [7:0]  w_shift_new;
    logic [4:0]  w_phase_new;

    // take a word when the output slot is free or being emptied
    assign w_pop       = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_q_pop     = w_pop;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;
    assign w_ticks     = (r_phase_ticks == '0) ? 16'd1 : r_phase_ticks;

    // sequencer state register and phase length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd         <= CMD_IDLE;
            r_phase       <= '0;
            r_tick        <= '0;
            r_shift       <= '0;
            r_lines       <= BUS_RELEASED;
            r_ack         <= 1'b0;
            r_rx          <= '0;
            r_phase_ticks <= PHASE_TICKS_RST;
        end else begin
            r_cmd   <= n_cmd;
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_shift <= n_shift;
            r_lines <= n_lines;
            r_ack   <= n_ack;
            r_rx    <= n_rx;
            if (i_cfg_we) begin
                r_phase_ticks <= i_cfg_wdata;
            end
        end
    end

    // next state and result word for one tick
    always_comb begin
        n_cmd   = r_cmd;
        n_phase = r_phase;
        n_tick  = r_tick;
        n_shift = r_shift;
        n_lines = r_lines;
        n_ack   = r_ack;
        n_rx    = r_rx;

        w_run   = 1'b0;
        w_cmd   = r_cmd;
        w_phase = r_phase;
        w_tick  = r_tick;
        w_shift = r_shift;
        w_ack   = r_ack;
        w_lines = r_lines;

        w_res.busy_res = 1'b0;
        w_res.done_res = 1'b0;
        w_res.status   = ST_OK;
        {w_res.scl_drive, w_res.scl_value, w_res.sda_drive, w_res.sda_value} = r_lines;

        w_tick_inc  = 17'({1'b0, w_tick}) + 17'd1;
        w_ack_new   = w_ack;
        w_shift_new = w_shift;
        w_phase_new = w_phase;

        if (w_pop) begin
            // idle: look at the offered command
            if (r_cmd == CMD_IDLE) begin
                case (i_q_item.kind)
                    KIND_BUS_BUSY: begin
                        n_lines        = BUS_RELEASED;
                        w_res.busy_res = 1'b1;
                        w_res.done_res = 1'b1;
                        w_res.status   = ST_BUS_BUSY;
                        {w_res.scl_drive, w_res.scl_value,
                         w_res.sda_drive, w_res.sda_value} = BUS_RELEASED;
                    end
                    KIND_CMD: begin
                        w_run   = 1'b1;
                        w_cmd   = i_q_item.cmd;
                        w_phase = '0;
                        w_tick  = '0;
                        w_shift = (w_cmd == CMD_WRITE) ? i_q_item.tx_byte : 8'd0;
                        w_ack   = (w_cmd == CMD_READ) ? i_q_item.send_ack : 1'b0;
                        w_lines = phase_lines(w_cmd, 5'd0, r_lines, w_shift, w_ack);
                    end
                    default: begin
                        w_run = 1'b0;
                    end
                endcase
            end else begin
                w_run = 1'b1;
            end

            // running: count ticks and advance phases
            if (w_run) begin
                w_res.busy_res = 1'b1;
                {w_res.scl_drive, w_res.scl_value, w_res.sda_drive, w_res.sda_value} = w_lines;
                w_tick_inc  = 17'({1'b0, w_tick}) + 17'd1;
                w_ack_new   = w_ack;
                w_shift_new = w_shift;
                w_phase_new = w_phase + 5'd1;
                if (w_tick_inc >= {1'b0, w_ticks}) begin
                    n_tick = '0;
                    // sample ack at end of write ack phase
                    if (w_cmd == CMD_WRITE && w_phase == WR_ACK_PHASE) begin
                        w_ack_new = i_q_item.sda_level;
                    end
                    // sample data at end of each high read clock phase
                    if (w_cmd == CMD_READ && w_phase >= 5'd1 &&
                        w_phase <= RD_LAST_BIT_PHASE && w_phase[0]) begin
                        w_shift_new = {w_shift[6:0], i_q_item.sda_level};
                    end
                    n_ack   = w_ack_new;
                    n_shift = w_shift_new;
                    if (w_phase_new >= phase_count(w_cmd)) begin
                        w_res.done_res = 1'b1;
                        if (w_cmd == CMD_WRITE && w_ack_new) begin
                            w_res.status = ST_NO_ACK;
                        end
                        if (w_cmd == CMD_READ) begin
                            n_rx = w_shift_new;
                        end
                        n_lines = (w_cmd == CMD_STOP) ? BUS_RELEASED : w_lines;
                        n_cmd   = CMD_IDLE;
                        n_phase = '0;
                    end else begin
                        n_lines = phase_lines(w_cmd, w_phase_new, w_lines, w_shift_new,
                                              w_ack_new);
                        n_phase = w_phase_new;
                        n_cmd   = w_cmd;
                    end
                end else begin
                    n_tick  = w_tick_inc[15:0];
                    n_cmd   = w_cmd;
                    n_phase = w_phase;
                    n_shift = w_shift;
                    n_ack   = w_ack;
                    n_lines = w_lines;
                end
            end
        end

        w_res.rx_byte = n_rx;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_out <= w_res;
        end
    end

    // checks
    `I2CMBE_ASSERT_COMB(a_idle_counters_clear, i_clk, i_rst_n, (r_cmd == CMD_IDLE), (r_phase == 5'd0 && r_tick == 16'd0), "phase or tick counter not clear while idle")
    `I2CMBE_ASSERT_COMB(a_phase_in_range, i_clk, i_rst_n, (r_cmd != CMD_IDLE), (r_phase < phase_count(r_cmd)), "phase beyond the command's phase list")
    `I2CMBE_ASSERT_NEXT(a_done_goes_idle, i_clk, i_rst_n, (w_pop && w_res.done_res && r_cmd != CMD_IDLE), (r_cmd == CMD_IDLE), "sequencer did not return to idle after done")
    `I2CMBE_ASSERT_COMB(a_no_ack_from_write, i_clk, i_rst_n, (w_pop && w_res.status == ST_NO_ACK), (r_cmd == CMD_WRITE && w_res.done_res), "no-ack status outside a finishing write")

endmodule

### design/i2c_master_bit_engine_core.sv
// top level of the i2c master bit engine: front end, word queue and phase sequencer
//
//  port group      dir  handshake                   payload
//  input word      in   i_in_valid / o_in_ready     cmd_valid func tx_byte send_ack scl/sda level
//  result word     out  o_out_valid / i_out_ready   line drives/values busy done status rx_byte
//  config          in   i_cfg_we (no wait)          i_cfg_wdata = phase_ticks
//
//  one word is taken per cycle if the queue has room; each word yields exactly one result word
//  a word enters the queue, then one sequencer step moves its result into the output register
//  the sequencer pops one word per cycle while the output register is free or being emptied
//  a stalled output fills the queue of QUEUE_DEPTH words, then o_in_ready drops
//  synchronous active-low reset; lines come up released, phase_ticks comes up as 4
module i2c_master_bit_engine_core import i2cmbe_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd_valid,
    input  logic [2:0]  i_func,
    input  logic [7:0]  i_tx_byte,
    input  logic        i_send_ack,
    input  logic        i_scl_level,
    input  logic        i_sda_level,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_scl_drive,
    output logic        o_scl_value,
    output logic        o_sda_drive,
    output logic        o_sda_value,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [1:0]  o_status,
    output logic [7:0]  o_rx_byte
);

    logic    w_full;
    logic    w_push;
    t_item   w_in_item;
    logic    w_q_valid;
    t_item   w_q_item;
    logic    w_q_pop;
    t_result w_result;

    // classify incoming words
    i2cmbe_front u_front (
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd_valid (i_cmd_valid),
        .i_func      (i_func),
        .i_tx_byte   (i_tx_byte),
        .i_send_ack  (i_send_ack),
        .i_scl_level (i_scl_level),
        .i_sda_level (i_sda_level),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_item      (w_in_item)
    );

    // word queue
    i2cmbe_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_q_pop)
    );

    // phase sequencer
    i2cmbe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_item),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (w_result)
    );

    // result word fields
    assign o_scl_drive = w_result.scl_drive;
    assign o_scl_value = w_result.scl_value;
    assign o_sda_drive = w_result.sda_drive;
    assign o_sda_value = w_result.sda_value;
    assign o_busy_res  = w_result.busy_res;
    assign o_done_res  = w_result.done_res;
    assign o_status    = w_result.status;
    assign o_rx_byte   = w_result.rx_byte;

endmodule

### tb/tb_i2c_master_bit_engine_core.sv
// self-checking testbench for the i2c master bit engine: directed table, then random bus traffic
module tb_i2c_master_bit_engine_core;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cmbe_pkg::*;

    // function codes not named by the package
    localparam logic [2:0] FN_RSTART = 3'd1;
    localparam logic [2:0] FN_WRITE  = 3'd2;
    localparam logic [2:0] FN_READ   = 3'd3;
    localparam logic [2:0] FN_RSVD5  = 3'd5;
    localparam logic [2:0] FN_RSVD6  = 3'd6;
    localparam logic [2:0] FN_RSVD7  = 3'd7;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_WORDS = 60;
    localparam int FINAL_WORDS = 80;
    localparam int LONG_HOLD   = 300;
    localparam int MAX_REPORTS = 10;

    // one input word: a sequencer tick with sampled lines and an optional command
    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] func;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       scl_level;
        logic       sda_level;
    } t_bus_tick;

    // one row of the directed table
    typedef struct packed {
        t_bus_tick tick;
        logic      settle;
        logic      typed;
        t_result   want;
    } t_script_row;

    // words that can be read straight off the spec
    localparam t_result RELEASED_RST_WORD = '{scl_drive: 1'b0, scl_value: 1'b1,
                                              sda_drive: 1'b0, sda_value: 1'b1,
                                              busy_res: 1'b0, done_res: 1'b0,
                                              status: ST_OK, rx_byte: 8'h00};
    localparam t_result BUS_TAKEN_WORD    = '{scl_drive: 1'b0, scl_value: 1'b1,
                                              sda_drive: 1'b0, sda_value: 1'b1,
                                              busy_res: 1'b1, done_res: 1'b1,
                                              status: ST_BUS_BUSY, rx_byte: 8'h00};

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [15:0] i_cfg_wdata = 16'd0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    logic        i_cmd_valid = 1'b0;
    logic [2:0]  i_func      = 3'd0;
    logic [7:0]  i_tx_byte   = 8'd0;
    logic        i_send_ack  = 1'b0;
    logic        i_scl_level = 1'b1;
    logic        i_sda_level = 1'b1;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_scl_drive;
    logic        o_scl_value;
    logic        o_sda_drive;
    logic        o_sda_value;
    logic        o_busy_res;
    logic        o_done_res;
    logic [1:0]  o_status;
    logic [7:0]  o_rx_byte;

    i2c_master_bit_engine_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd_valid (i_cmd_valid),
        .i_func      (i_func),
        .i_tx_byte   (i_tx_byte),
        .i_send_ack  (i_send_ack),
        .i_scl_level (i_scl_level),
        .i_sda_level (i_sda_level),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_scl_drive (o_scl_drive),
        .o_scl_value (o_scl_value),
        .o_sda_drive (o_sda_drive),
        .o_sda_value (o_sda_value),
        .o_busy_res  (o_busy_res),
        .o_done_res  (o_done_res),
        .o_status    (o_status),
        .o_rx_byte   (o_rx_byte)
    );

    // clock, 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // sequencer mirror: command, phase position, shifter, tick count, line word, ack, last read byte
    t_cmd        seq_cmd    = CMD_IDLE;
    logic [4:0]  seq_phase  = 5'd0;
    logic [7:0]  seq_shift  = 8'h00;
    logic [15:0] seq_ticks  = 16'd0;
    logic [3:0]  seq_pins   = BUS_RELEASED;
    logic        seq_ack    = 1'b0;
    logic [7:0]  seq_rx     = 8'h00;
    logic [15:0] phase_len  = PHASE_TICKS_RST;

    t_result     predicted_pins [$];
    t_script_row script [$];
    logic [15:0] period_plan [7];
    bit          bus_open   = 1'b0;
    bit          gaps_on    = 1'b1;
    bit          stall_req  = 1'b0;
    int          mismatches = 0;
    int          cycle_count;

    function automatic logic [3:0] both_pins(input logic scl_v, input logic sda_v);
        return {1'b1, scl_v, 1'b1, sda_v};
    endfunction

    // number of line phases in each command
    function automatic logic [4:0] phases_of(input t_cmd op);
        case (op)
            CMD_START:  return 5'd2;
            CMD_RSTART: return 5'd4;
            CMD_WRITE:  return 5'd26;
            CMD_READ:   return 5'd19;
            default:    return 5'd4;
        endcase
    endfunction

    // line word held during phase ph of a command
    function automatic logic [3:0] pin_pattern(input t_cmd op, input logic [4:0] ph,
                                               input logic [3:0] now);
        logic        keep;
        int unsigned slot;
        int unsigned sub;
        keep = now[0];
        slot = ph / 3;
        sub  = ph % 3;
        case (op)
            CMD_START: begin
                return (ph == 5'd0) ? both_pins(1'b1, 1'b1) : both_pins(1'b1, 1'b0);
            end
            CMD_RSTART: begin
                if (ph == 5'd0) return both_pins(1'b0, keep);
                if (ph == 5'd1) return both_pins(1'b0, 1'b1);
                if (ph == 5'd2) return both_pins(1'b1, 1'b1);
                return both_pins(1'b1, 1'b0);
            end
            CMD_WRITE: begin
                // three phases per bit, then scl low, then sda released for the ack
                if (ph < WR_BIT_PHASES) begin
                    if (sub == 0) return both_pins(1'b0, keep);
                    return both_pins(sub == 2, seq_shift[7 - slot]);
                end
                if (ph == WR_BIT_PHASES) return both_pins(1'b0, keep);
                return {3'b110, keep};
            end
            CMD_READ: begin
                // sda released while scl toggles, then ack or nack driven
                if (ph == 5'd0) return {3'b100, keep};
                if (ph <= RD_LAST_BIT_PHASE) return {1'b1, ph[0], 1'b0, keep};
                if (ph == RD_ACK_PHASE) return {3'b101, ~seq_ack};
                return {3'b111, ~seq_ack};
            end
            default: begin
                if (ph == 5'd0) return both_pins(1'b0, keep);
                if (ph == 5'd1) return both_pins(1'b0, 1'b0);
                if (ph == 5'd2) return both_pins(1'b1, 1'b0);
                return both_pins(1'b1, 1'b1);
            end
        endcase
    endfunction

    // advance the mirror by one tick and return the word the block should put out
    function automatic t_result advance_sequencer(input t_bus_tick t);
        t_result     w;
        logic [15:0] hold;
        logic [3:0]  out_pins;
        logic        busy;
        logic        done;
        t_status     st;
        hold     = (phase_len == 16'd0) ? 16'd1 : phase_len;
        out_pins = seq_pins;
        busy     = 1'b0;
        done     = 1'b0;
        st       = ST_OK;
        // command taken only when idle and the code is known
        if (seq_cmd == CMD_IDLE && t.cmd_valid && t.func <= FUNC_STOP) begin
            if (t.func == FUNC_START && !(t.scl_level && t.sda_level)) begin
                // bus held by someone else: release and finish at once
                seq_pins = BUS_RELEASED;
                out_pins = BUS_RELEASED;
                busy     = 1'b1;
                done     = 1'b1;
                st       = ST_BUS_BUSY;
            end else begin
                seq_cmd   = t_cmd'(t.func + 3'd1);
                seq_phase = 5'd0;
                seq_ticks = 16'd0;
                seq_shift = (t.func == FN_WRITE) ? t.tx_byte : 8'h00;
                seq_ack   = (t.func == FN_READ) ? t.send_ack : 1'b0;
                seq_pins  = pin_pattern(seq_cmd, 5'd0, seq_pins);
            end
        end
        // phase timing and sampling
        if (seq_cmd != CMD_IDLE) begin
            out_pins  = seq_pins;
            busy      = 1'b1;
            seq_ticks = seq_ticks + 16'd1;
            if (seq_ticks >= hold) begin
                seq_ticks = 16'd0;
                if (seq_cmd == CMD_WRITE && seq_phase == WR_ACK_PHASE)
                    seq_ack = t.sda_level;
                if (seq_cmd == CMD_READ && seq_phase >= 5'd1 &&
                    seq_phase <= RD_LAST_BIT_PHASE && seq_phase[0])
                    seq_shift = {seq_shift[6:0], t.sda_level};
                seq_phase = seq_phase + 5'd1;
                if (seq_phase >= phases_of(seq_cmd)) begin
                    done = 1'b1;
                    if (seq_cmd == CMD_WRITE && seq_ack) st = ST_NO_ACK;
                    if (seq_cmd == CMD_READ) seq_rx = seq_shift;
                    if (seq_cmd == CMD_STOP) seq_pins = BUS_RELEASED;
                    seq_cmd   = CMD_IDLE;
                    seq_phase = 5'd0;
                end else begin
                    seq_pins = pin_pattern(seq_cmd, seq_phase, seq_pins);
                end
            end
        end
        w.scl_drive = out_pins[3];
        w.scl_value = out_pins[2];
        w.sda_drive = out_pins[1];
        w.sda_value = out_pins[0];
        w.busy_res  = busy;
        w.done_res  = done;
        w.status    = st;
        w.rx_byte   = seq_rx;
        return w;
    endfunction

    function automatic t_bus_tick tick_of(input logic cv, input logic [2:0] fn,
                                          input logic [7:0] tx, input logic ack,
                                          input logic scl, input logic sda);
        return '{cmd_valid: cv, func: fn, tx_byte: tx, send_ack: ack,
                 scl_level: scl, sda_level: sda};
    endfunction

    // random traffic: mostly start / transfers / stop on a free bus, some noise
    function automatic t_bus_tick pick_tick();
        t_bus_tick t;
        int        roll;
        int        pick;
        t.cmd_valid = 1'b0;
        t.func      = 3'($urandom_range(0, 7));
        t.tx_byte   = 8'($urandom);
        t.send_ack  = 1'($urandom);
        t.scl_level = ($urandom_range(0, 19) != 0);
        t.sda_level = 1'($urandom);
        roll        = $urandom_range(0, 99);
        pick        = $urandom_range(0, 99);
        if (seq_cmd != CMD_IDLE) begin
            // offers while busy are ignored
            t.cmd_valid = (roll < 8);
        end else if (roll < 12) begin
            t.cmd_valid = 1'($urandom);
            t.scl_level = 1'($urandom);
        end else if (roll >= 20) begin
            t.cmd_valid = 1'b1;
            if (!bus_open) begin
                t.func      = FUNC_START;
                t.scl_level = 1'b1;
                t.sda_level = 1'b1;
            end else if (pick < 40) begin
                t.func = FN_WRITE;
            end else if (pick < 70) begin
                t.func = FN_READ;
            end else if (pick < 82) begin
                t.func = FN_RSTART;
            end else begin
                t.func = FUNC_STOP;
            end
        end
        return t;
    endfunction

    // offer one word, wait for it to be taken, then record what it should produce
    task automatic send_tick(input t_bus_tick t, input logic typed, input t_result typed_word);
        t_result guess;
        bit      was_free;
        if (gaps_on && $urandom_range(0, 15) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_cmd_valid <= t.cmd_valid;
        i_func      <= t.func;
        i_tx_byte   <= t.tx_byte;
        i_send_ack  <= t.send_ack;
        i_scl_level <= t.scl_level;
        i_sda_level <= t.sda_level;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        was_free = (seq_cmd == CMD_IDLE);
        guess    = advance_sequencer(t);
        predicted_pins.push_back(typed ? typed_word : guess);
        if (was_free && t.cmd_valid && t.func == FUNC_START) bus_open = (guess.status == ST_OK);
        if (was_free && t.cmd_valid && t.func == FUNC_STOP) bus_open = 1'b0;
    endtask

    // stop sending and wait until every predicted word has come out
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (predicted_pins.size() != 0);
    endtask

    // let the running command finish, drain, then load a new phase length
    task automatic set_period(input logic [15:0] value);
        t_bus_tick pad;
        while (seq_cmd != CMD_IDLE) begin
            pad           = pick_tick();
            pad.cmd_valid = 1'b0;
            send_tick(pad, 1'b0, '0);
        end
        drain_results();
        repeat (3) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        phase_len = value;
    endtask

    // compare each result word with the oldest prediction
    always @(posedge i_clk) begin : check_words
        t_result got;
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.scl_drive = o_scl_drive;
            got.scl_value = o_scl_value;
            got.sda_drive = o_sda_drive;
            got.sda_value = o_sda_value;
            got.busy_res  = o_busy_res;
            got.done_res  = o_done_res;
            got.status    = t_status'(o_status);
            got.rx_byte   = o_rx_byte;
            if (predicted_pins.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected word: pins %b%b%b%b busy %b done %b st %0d rx %h",
                             got.scl_drive, got.scl_value, got.sda_drive, got.sda_value,
                             got.busy_res, got.done_res, got.status, got.rx_byte);
            end else begin
                want = predicted_pins.pop_front();
                if (got.scl_drive !== want.scl_drive || got.scl_value !== want.scl_value ||
                    got.sda_drive !== want.sda_drive || got.sda_value !== want.sda_value ||
                    got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
                    got.status !== want.status || got.rx_byte !== want.rx_byte) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"word mismatch: exp pins %b%b%b%b busy %b done %b st %0d ",
                                  "rx %h, got pins %b%b%b%b busy %b done %b st %0d rx %h"},
                                 want.scl_drive, want.scl_value, want.sda_drive,
                                 want.sda_value, want.busy_res, want.done_res, want.status,
                                 want.rx_byte, got.scl_drive, got.scl_value, got.sda_drive,
                                 got.sda_value, got.busy_res, got.done_res, got.status,
                                 got.rx_byte);
                end
            end
        end
    end

    // result side: random stall bursts and one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (stall_req) begin
                stall_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else if (gaps_on && $urandom_range(0, 11) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // hang guard
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // main sequence
    initial begin
        t_bus_tick pad;
        period_plan = '{16'd1, 16'd0, 16'd2, 16'd3, 16'd4, 16'd1, 16'hFFFF};

        // directed table, run at the reset phase length
        script.push_back('{tick_of(1'b0, FUNC_START, 8'h00, 1'b0, 1'b1, 1'b1),
                           1'b0, 1'b1, RELEASED_RST_WORD});
        // start with a line held low reports bus busy
        script.push_back('{tick_of(1'b1, FUNC_START, 8'h00, 1'b0, 1'b0, 1'b1),
                           1'b0, 1'b1, BUS_TAKEN_WORD});
        script.push_back('{tick_of(1'b1, FUNC_START, 8'hFF, 1'b1, 1'b1, 1'b0),
                           1'b0, 1'b1, BUS_TAKEN_WORD});
        script.push_back('{tick_of(1'b1, FUNC_START, 8'h00, 1'b0, 1'b0, 1'b0),
                           1'b0, 1'b1, BUS_TAKEN_WORD});
        // unknown codes are ignored
        script.push_back('{tick_of(1'b1, FN_RSVD5, 8'hFF, 1'b1, 1'b1, 1'b1),
                           1'b0, 1'b1, RELEASED_RST_WORD});
        script.push_back('{tick_of(1'b1, FN_RSVD6, 8'h00, 1'b0, 1'b0, 1'b0),
                           1'b0, 1'b1, RELEASED_RST_WORD});
        script.push_back('{tick_of(1'b1, FN_RSVD7, 8'hFF, 1'b1, 1'b1, 1'b1),
                           1'b0, 1'b1, RELEASED_RST_WORD});
        // start, then a write offered while it runs
        script.push_back('{tick_of(1'b1, FUNC_START, 8'h00, 1'b0, 1'b1, 1'b1),
                           1'b0, 1'b0, t_result'('0)});
        script.push_back('{tick_of(1'b1, FN_WRITE, 8'h3C, 1'b0, 1'b1, 1'b1),
                           1'b1, 1'b0, t_result'('0)});
        // write with nack, write with ack
        script.push_back('{tick_of(1'b1, FN_WRITE, 8'hFF, 1'b0, 1'b1, 1'b1),
                           1'b1, 1'b0, t_result'('0)});
        script.push_back('{tick_of(1'b1, FN_WRITE, 8'h00, 1'b1, 1'b1, 1'b0),
                           1'b1, 1'b0, t_result'('0)});
        // read all ones then ack
        script.push_back('{tick_of(1'b1, FN_READ, 8'h00, 1'b1, 1'b1, 1'b1),
                           1'b1, 1'b0, t_result'('0)});
        script.push_back('{tick_of(1'b1, FN_RSTART, 8'hFF, 1'b1, 1'b1, 1'b1),
                           1'b1, 1'b0, t_result'('0)});
        script.push_back('{tick_of(1'b1, FN_WRITE, 8'hA5, 1'b0, 1'b1, 1'b0),
                           1'b1, 1'b0, t_result'('0)});
        // read all zeros then nack
        script.push_back('{tick_of(1'b1, FN_READ, 8'hFF, 1'b0, 1'b1, 1'b0),
                           1'b1, 1'b0, t_result'('0)});
        script.push_back('{tick_of(1'b1, FUNC_STOP, 8'h00, 1'b0, 1'b1, 1'b1),
                           1'b1, 1'b0, t_result'('0)});
        // stop and repeated start on a free bus
        script.push_back('{tick_of(1'b1, FUNC_STOP, 8'h5A, 1'b1, 1'b0, 1'b0),
                           1'b1, 1'b0, t_result'('0)});
        script.push_back('{tick_of(1'b1, FN_RSTART, 8'h00, 1'b0, 1'b1, 1'b1),
                           1'b1, 1'b0, t_result'('0)});
        // scl level has no effect outside the start check
        script.push_back('{tick_of(1'b1, FN_READ, 8'h5A, 1'b1, 1'b0, 1'b1),
                           1'b1, 1'b0, t_result'('0)});
        script.push_back('{tick_of(1'b1, FUNC_START, 8'h00, 1'b0, 1'b1, 1'b0),
                           1'b0, 1'b0, t_result'('0)});

        // reset
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // walk the table, running each command to its end where asked
        foreach (script[i]) begin
            send_tick(script[i].tick, script[i].typed, script[i].want);
            if (script[i].settle) begin
                pad           = script[i].tick;
                pad.cmd_valid = 1'b0;
                while (seq_cmd != CMD_IDLE) send_tick(pad, 1'b0, '0);
            end
        end
        bus_open = 1'b0;

        // random traffic over a range of phase lengths, the longest last
        for (int k = 0; k < 7; k++) begin
            set_period(period_plan[k]);
            gaps_on = (k != 3 && k != 6);
            for (int n = 0; n < ((k == 6) ? FINAL_WORDS : PHASE_WORDS); n++) begin
                if (k == 2 && n == 40) stall_req = 1'b1;
                if (k == 1 && n == 30) drain_results();
                send_tick(pick_tick(), 1'b0, '0);
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && predicted_pins.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
